@@ src/ccs_pkg.sv @@
// Shared types, constants and helpers for the crystal crosstalk spreader.
// No dependencies; every other file in src/ refers to this package.
`default_nettype none

package ccs_pkg;

  localparam int unsigned MAX_SIDE   = 256;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned ENERGY_W   = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned WEIGHT_W   = FRAC_W + 1;        // 1.0 in Q0.16 needs 17 bits
  localparam int unsigned ONE_Q16    = 1 << FRAC_W;
  localparam int unsigned NB_NUM     = 18;                // 6 face + 12 diagonal
  localparam int unsigned FACE_NUM   = 6;
  localparam int unsigned IDX_W      = $clog2(NB_NUM);
  localparam int unsigned SUM_W      = FRAC_W + $clog2(NB_NUM) + 1;
  localparam int unsigned REDUCE_W   = FRAC_W + 3;        // 4*edge + 4*corner
  localparam int unsigned PROD_W     = ENERGY_W + WEIGHT_W;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_FRACTION   = 3'd0,
    REG_CORNER_FRACTION = 3'd1,
    REG_SIZE_X          = 3'd2,
    REG_SIZE_Y          = 3'd3,
    REG_SIZE_Z          = 3'd4
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_FACE = 2'd0,
    KIND_DIAG = 2'd1,
    KIND_ORIG = 2'd2
  } hit_kind_t;

  // per-axis step of a neighbor
  typedef enum logic [1:0] {
    OFF_NONE = 2'd0,
    OFF_DN   = 2'd1,
    OFF_UP   = 2'd2
  } off_t;

  typedef struct packed {
    off_t dx;
    off_t dy;
    off_t dz;
  } nb_off_t;

  // emission order: faces, then in-plane diagonals
  localparam nb_off_t NB_OFF [NB_NUM] = '{
    '{OFF_DN,   OFF_NONE, OFF_NONE},
    '{OFF_UP,   OFF_NONE, OFF_NONE},
    '{OFF_NONE, OFF_DN,   OFF_NONE},
    '{OFF_NONE, OFF_UP,   OFF_NONE},
    '{OFF_NONE, OFF_NONE, OFF_DN  },
    '{OFF_NONE, OFF_NONE, OFF_UP  },
    '{OFF_DN,   OFF_DN,   OFF_NONE},
    '{OFF_DN,   OFF_UP,   OFF_NONE},
    '{OFF_DN,   OFF_NONE, OFF_DN  },
    '{OFF_DN,   OFF_NONE, OFF_UP  },
    '{OFF_UP,   OFF_DN,   OFF_NONE},
    '{OFF_UP,   OFF_UP,   OFF_NONE},
    '{OFF_UP,   OFF_NONE, OFF_DN  },
    '{OFF_UP,   OFF_NONE, OFF_UP  },
    '{OFF_NONE, OFF_DN,   OFF_DN  },
    '{OFF_NONE, OFF_DN,   OFF_UP  },
    '{OFF_NONE, OFF_UP,   OFF_DN  },
    '{OFF_NONE, OFF_UP,   OFF_UP  }
  };

  typedef struct packed {
    logic [FRAC_W-1:0]   edge_frac;
    logic [FRAC_W-1:0]   corner_frac;
    logic [SIZE_W-1:0]   size_x;     // clamped to 1..MAX_SIDE
    logic [SIZE_W-1:0]   size_y;
    logic [SIZE_W-1:0]   size_z;
    logic [WEIGHT_W-1:0] weight;     // weight of the reduced original
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [POS_W-1:0]    z;
    logic [ENERGY_W-1:0] energy;
    logic [WEIGHT_W-1:0] frac;
    hit_kind_t           kind;
    logic                flag;
    logic                last;
  } emit_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_W'(MAX_SIDE)) begin
      r = SIZE_W'(MAX_SIDE);
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic axis_ok(input logic [POS_W-1:0] pos, input off_t off,
                                   input logic [SIZE_W-1:0] size);
    logic r;
    case (off)
      OFF_DN:  r = (pos != '0);
      OFF_UP:  r = ((SIZE_W'(pos) + SIZE_W'(1)) < size);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] pos,
                                                input off_t off);
    logic [POS_W-1:0] r;
    case (off)
      OFF_DN:  r = pos - POS_W'(1);
      OFF_UP:  r = pos + POS_W'(1);
      default: r = pos;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/ccs_ifs.sv @@
// Handshake channels of the spreader: incoming hits and emitted hits.
// Depends on ccs_pkg for field widths.
`default_nettype none

interface ccs_hit_if;
  logic                            valid;
  logic                            ready;
  logic [ccs_pkg::POS_W-1:0]       pos_x;
  logic [ccs_pkg::POS_W-1:0]       pos_y;
  logic [ccs_pkg::POS_W-1:0]       pos_z;
  logic [ccs_pkg::ENERGY_W-1:0]    hit_energy;

  modport source (output valid, pos_x, pos_y, pos_z, hit_energy, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, hit_energy, output ready);
endinterface

interface ccs_res_if;
  logic                            valid;
  logic                            ready;
  logic [ccs_pkg::POS_W-1:0]       out_x;
  logic [ccs_pkg::POS_W-1:0]       out_y;
  logic [ccs_pkg::POS_W-1:0]       out_z;
  logic [ccs_pkg::ENERGY_W-1:0]    out_energy;
  logic [ccs_pkg::KIND_W-1:0]      hit_kind;
  logic                            too_much_energy;
  logic                            last;

  modport source (output valid, out_x, out_y, out_z, out_energy, hit_kind,
                  too_much_energy, last, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_energy, hit_kind,
                  too_much_energy, last, output ready);
endinterface

`default_nettype wire

@@ src/ccs_cfg.sv @@
// Configuration registers plus derived values (clamped sizes, original weight).
// Depends on ccs_pkg.
`default_nettype none

module ccs_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ccs_pkg::CFG_DATA_W-1:0] cfg_data,
  output ccs_pkg::cfg_t                       cfg
);

  logic [ccs_pkg::FRAC_W-1:0]   edge_fraction;
  logic [ccs_pkg::FRAC_W-1:0]   corner_fraction;
  logic [ccs_pkg::SIZE_W-1:0]   size_x;
  logic [ccs_pkg::SIZE_W-1:0]   size_y;
  logic [ccs_pkg::SIZE_W-1:0]   size_z;
  logic [ccs_pkg::REDUCE_W-1:0] reduce;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_fraction   <= '0;
      corner_fraction <= '0;
      size_x          <= ccs_pkg::SIZE_W'(1);
      size_y          <= ccs_pkg::SIZE_W'(1);
      size_z          <= ccs_pkg::SIZE_W'(1);
    end else if (cfg_we) begin
      case (ccs_pkg::cfg_reg_t'(cfg_index))
        ccs_pkg::REG_EDGE_FRACTION:   edge_fraction   <= cfg_data;
        ccs_pkg::REG_CORNER_FRACTION: corner_fraction <= cfg_data;
        ccs_pkg::REG_SIZE_X:          size_x <= cfg_data[ccs_pkg::SIZE_W-1:0];
        ccs_pkg::REG_SIZE_Y:          size_y <= cfg_data[ccs_pkg::SIZE_W-1:0];
        ccs_pkg::REG_SIZE_Z:          size_z <= cfg_data[ccs_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    reduce = (ccs_pkg::REDUCE_W'(edge_fraction) << 2)
           + (ccs_pkg::REDUCE_W'(corner_fraction) << 2);
    cfg.edge_frac   = edge_fraction;
    cfg.corner_frac = corner_fraction;
    cfg.size_x      = ccs_pkg::eff_size(size_x);
    cfg.size_y      = ccs_pkg::eff_size(size_y);
    cfg.size_z      = ccs_pkg::eff_size(size_z);
    if (reduce >= ccs_pkg::REDUCE_W'(ccs_pkg::ONE_Q16)) begin
      cfg.weight = '0;
    end else begin
      cfg.weight = ccs_pkg::WEIGHT_W'(ccs_pkg::REDUCE_W'(ccs_pkg::ONE_Q16) - reduce);
    end
  end

endmodule

`default_nettype wire

@@ src/ccs_seq.sv @@
// Hold register for the current hit and the neighbor sequencer.
// Depends on ccs_pkg and ccs_hit_if.
`default_nettype none

module ccs_seq (
  input  wire logic   clk,
  input  wire logic   rst,
  input  ccs_pkg::cfg_t cfg,
  ccs_hit_if.sink     hit,
  input  wire logic   take,
  output logic        emit_valid,
  output ccs_pkg::emit_t emit
);

  logic                          hold_valid;
  logic [ccs_pkg::POS_W-1:0]     hold_x;
  logic [ccs_pkg::POS_W-1:0]     hold_y;
  logic [ccs_pkg::POS_W-1:0]     hold_z;
  logic [ccs_pkg::ENERGY_W-1:0]  hold_energy;
  logic [ccs_pkg::NB_NUM-1:0]    mask;       // neighbors still to emit
  logic [ccs_pkg::NB_NUM-1:0]    mask_next;  // presence mask of the incoming hit
  logic [ccs_pkg::SUM_W-1:0]     sum_acc;    // fractions emitted so far

  logic [ccs_pkg::IDX_W-1:0]     idx;
  logic                          have_nb;
  logic                          fire;
  logic                          finish;
  logic                          accept;

  // presence of each neighbor, gated by its fraction being nonzero
  always_comb begin
    for (int i = 0; i < ccs_pkg::NB_NUM; i++) begin
      mask_next[i] = ccs_pkg::axis_ok(hit.pos_x, ccs_pkg::NB_OFF[i].dx, cfg.size_x)
                   & ccs_pkg::axis_ok(hit.pos_y, ccs_pkg::NB_OFF[i].dy, cfg.size_y)
                   & ccs_pkg::axis_ok(hit.pos_z, ccs_pkg::NB_OFF[i].dz, cfg.size_z)
                   & ((i < ccs_pkg::FACE_NUM) ? (cfg.edge_frac != '0)
                                              : (cfg.corner_frac != '0));
    end
  end

  // lowest pending neighbor goes first
  always_comb begin
    idx = '0;
    for (int i = ccs_pkg::NB_NUM - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = ccs_pkg::IDX_W'(i);
      end
    end
  end

  assign have_nb = |mask;

  always_comb begin
    if (have_nb) begin
      emit.x      = ccs_pkg::step_pos(hold_x, ccs_pkg::NB_OFF[idx].dx);
      emit.y      = ccs_pkg::step_pos(hold_y, ccs_pkg::NB_OFF[idx].dy);
      emit.z      = ccs_pkg::step_pos(hold_z, ccs_pkg::NB_OFF[idx].dz);
      emit.energy = hold_energy;
      if (idx < ccs_pkg::IDX_W'(ccs_pkg::FACE_NUM)) begin
        emit.frac = ccs_pkg::WEIGHT_W'(cfg.edge_frac);
        emit.kind = ccs_pkg::KIND_FACE;
      end else begin
        emit.frac = ccs_pkg::WEIGHT_W'(cfg.corner_frac);
        emit.kind = ccs_pkg::KIND_DIAG;
      end
      emit.flag = 1'b0;
      emit.last = 1'b0;
    end else begin
      emit.x      = hold_x;
      emit.y      = hold_y;
      emit.z      = hold_z;
      emit.energy = hold_energy;
      emit.frac   = cfg.weight;
      emit.kind   = ccs_pkg::KIND_ORIG;
      emit.flag   = (hold_energy == '0)
                  || (sum_acc >= ccs_pkg::SUM_W'(ccs_pkg::ONE_Q16));
      emit.last   = 1'b1;
    end
  end

  assign emit_valid = hold_valid;
  assign fire       = hold_valid && take;
  assign finish     = fire && !have_nb;
  assign hit.ready  = !hold_valid || finish;
  assign accept     = hit.valid && hit.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (finish) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_x      <= hit.pos_x;
      hold_y      <= hit.pos_y;
      hold_z      <= hit.pos_z;
      hold_energy <= hit.hit_energy;
      mask        <= mask_next;
      sum_acc     <= '0;
    end else if (fire && have_nb) begin
      mask    <= mask & (mask - ccs_pkg::NB_NUM'(1));
      sum_acc <= sum_acc + ccs_pkg::SUM_W'(emit.frac);
    end
  end

endmodule

`default_nettype wire

@@ src/ccs_emit.sv @@
// Energy scaling and the result register driving the output channel.
// Depends on ccs_pkg and ccs_res_if.
`default_nettype none

module ccs_emit (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      emit_valid,
  input  ccs_pkg::emit_t emit,
  output logic           take,
  ccs_res_if.source      res
);

  logic                            out_valid;
  logic [ccs_pkg::POS_W-1:0]       out_x;
  logic [ccs_pkg::POS_W-1:0]       out_y;
  logic [ccs_pkg::POS_W-1:0]       out_z;
  logic [ccs_pkg::ENERGY_W-1:0]    out_energy;
  logic [ccs_pkg::KIND_W-1:0]      out_kind;
  logic                            out_flag;
  logic                            out_last;
  logic [ccs_pkg::PROD_W-1:0]      prod;

  // E * frac in Q0.16; result never exceeds E, so bits above stay zero
  assign prod = ccs_pkg::PROD_W'(emit.energy) * ccs_pkg::PROD_W'(emit.frac);
  assign take = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit_valid) begin
      out_x      <= emit.x;
      out_y      <= emit.y;
      out_z      <= emit.z;
      out_energy <= prod[ccs_pkg::FRAC_W +: ccs_pkg::ENERGY_W];
      out_kind   <= emit.kind;
      out_flag   <= emit.flag;
      out_last   <= emit.last;
    end
  end

  assign res.valid           = out_valid;
  assign res.out_x           = out_x;
  assign res.out_y           = out_y;
  assign res.out_z           = out_z;
  assign res.out_energy      = out_energy;
  assign res.hit_kind        = out_kind;
  assign res.too_much_energy = out_flag;
  assign res.last            = out_last;

endmodule

`default_nettype wire

@@ src/crystal_crosstalk_spreader.sv @@
// Top level of the crystal crosstalk spreader.
// Depends on ccs_pkg, ccs_ifs (ccs_hit_if, ccs_res_if), ccs_cfg, ccs_seq, ccs_emit.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+---------------------------------------------
//   hit      | in  | valid/ready    | pos_x, pos_y, pos_z, hit_energy
//   res      | out | valid/ready    | out_x/y/z, out_energy, hit_kind,
//            |     |                | too_much_energy, last
//   cfg      | in  | cfg_we only    | cfg_index (register), cfg_data
//
// Each hit occupies the hold register while its N neighbors (0..18) and then
// the original are emitted; one request leaves per cycle while res is not
// stalled, set by the single result register. A taken hit loads the hold
// register, and its first request then moves into the result register and on
// to res. The next hit loads in the cycle the current one's final request moves
// into the result register, so hits follow with no gap.
// rst is synchronous, active high; it clears valids and fractions, sets sizes to 1.
// A stall on res holds the result register and the hold register together;
// hit.ready stays low while a held hit is waiting.
`default_nettype none

module crystal_crosstalk_spreader (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ccs_pkg::CFG_DATA_W-1:0] cfg_data,
  ccs_hit_if.sink                             hit,
  ccs_res_if.source                           res
);

  ccs_pkg::cfg_t  cfg;     // live config, sizes already clamped
  ccs_pkg::emit_t emit;    // next request from the sequencer
  logic           emit_valid;
  logic           take;    // result register can load this cycle

  ccs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // walks the neighbor mask of the held hit, original hit last
  ccs_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .hit        (hit),
    .take       (take),
    .emit_valid (emit_valid),
    .emit       (emit)
  );

  // scales the energy and registers the request
  ccs_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .emit_valid (emit_valid),
    .emit       (emit),
    .take       (take),
    .res        (res)
  );

endmodule

`default_nettype wire
